// File: hdl/dtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtt_pkg;

  // Tile sizes are powers of two, so cell-to-tile conversion is a shift.
  localparam int TILE_W_LOG2 = 4;
  localparam int TILE_H_LOG2 = 4;
  localparam int TILE_W      = 1 << TILE_W_LOG2;
  localparam int TILE_H      = 1 << TILE_H_LOG2;
  localparam int GRID_W      = 512;
  localparam int GRID_H      = 512;
  localparam int TILES_X     = GRID_W / TILE_W;
  localparam int TILES_Y     = GRID_H / TILE_H;
  localparam int TX_W        = $clog2(TILES_X);
  localparam int ROW_W       = $clog2(TILES_Y);

  // Signed coordinate width wide enough for tile edges and the widened window.
  localparam int COORD_W     = 13;

  typedef enum logic [1:0] {
    KIND_REDRAW = 2'd0,
    KIND_REGION = 2'd1,
    KIND_RANGE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_VIEW_MIN_X = 2'd0,
    CFG_VIEW_MIN_Y = 2'd1,
    CFG_VIEW_MAX_X = 2'd2,
    CFG_VIEW_MAX_Y = 2'd3
  } cfg_reg_t;

  localparam logic FUNC_MARK = 1'b0;
  localparam logic FUNC_SCAN = 1'b1;

  typedef struct packed {
    kind_t      kind;
    logic [9:0] min_x;
    logic [9:0] min_y;
    logic [9:0] max_x;
    logic [9:0] max_y;
  } res_t;

  // Widened view window, edges in cells.
  typedef struct packed {
    logic signed [COORD_W-1:0] x_lo;
    logic signed [COORD_W-1:0] x_hi;
    logic signed [COORD_W-1:0] y_lo;
    logic signed [COORD_W-1:0] y_hi;
  } win_t;

endpackage

`default_nettype wire

// File: hdl/dtt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/dtt_window.sv
`timescale 1ns / 1ps
`default_nettype none

module dtt_window (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_data,
  output dtt_pkg::win_t   win
);

  import dtt_pkg::*;

  logic [8:0] view_min_x;
  logic [8:0] view_min_y;
  logic [9:0] view_max_x;
  logic [9:0] view_max_y;

  logic signed [COORD_W-1:0] mnx, mny, mxx, mxy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_min_x <= '0;
      view_min_y <= '0;
      view_max_x <= 10'd512;
      view_max_y <= 10'd512;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_VIEW_MIN_X: view_min_x <= cfg_data[8:0];
        CFG_VIEW_MIN_Y: view_min_y <= cfg_data[8:0];
        CFG_VIEW_MAX_X: view_max_x <= cfg_data;
        CFG_VIEW_MAX_Y: view_max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mnx = signed'(COORD_W'(view_min_x));
    mny = signed'(COORD_W'(view_min_y));
    mxx = signed'(COORD_W'(view_max_x));
    mxy = signed'(COORD_W'(view_max_y));
  end

  // The window grows by its own size on each side: lo = 2*min - max, hi = 2*max - min.
  always_ff @(posedge clk) begin
    win.x_lo <= (mnx <<< 1) - mxx;
    win.x_hi <= (mxx <<< 1) - mnx;
    win.y_lo <= (mny <<< 1) - mxy;
    win.y_hi <= (mxy <<< 1) - mny;
  end

endmodule

`default_nettype wire

// File: hdl/dirty_tile_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Mark request: ST_MK_WR writes the cell's tile row; ST_MK_NB follows when the cell
// lies on a horizontal tile edge (the pending memory is read, modified and written
// once per touched tile row). Out-of-range mark: one error result, loaded from
// ST_MK_ERR once the result register is free. Scan request: ST_SC_LD, ST_SC_WALK
// (one tile per cycle unless an output stall holds it), ST_SC_END and ST_SC_FIN.
// Reset clears the flag-row valid bits, so both bitmaps read as clean.
`default_nettype none

module dirty_tile_tracker (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input requests.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // cell_x[9:0], cell_y[19:10], tile_row[24:20], zeros
  input  wire logic [0:0]  s_tuser,   // func[0]
  // Results.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // box_min_x[9:0], box_min_y[19:10],
                                      // box_max_x[29:20], box_max_y[39:30]
  output logic [1:0]       m_tuser,   // kind[1:0]
  output logic             m_tlast,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  import dtt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MK_WR,
    ST_MK_NB,
    ST_MK_ERR,
    ST_SC_LD,
    ST_SC_WALK,
    ST_SC_END,
    ST_SC_FIN
  } state_t;

  state_t state;

  win_t win;

  dtt_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win)
  );

  // Input decode.
  logic [9:0]         in_x, in_y;
  logic [4:0]         in_row;
  logic               in_func;
  logic               in_oor, in_row_ok;
  logic [TX_W-1:0]    in_tx;
  logic [ROW_W-1:0]   in_ty, in_row_a;
  logic               edge_l, edge_r, edge_d, edge_u;
  logic [TILES_X-1:0] in_mask, in_bit;

  assign in_x    = s_tdata[9:0];
  assign in_y    = s_tdata[19:10];
  assign in_row  = s_tdata[24:20];
  assign in_func = s_tuser[0];

  always_comb begin
    in_oor    = (32'(in_x) >= GRID_W) || (32'(in_y) >= GRID_H);
    in_row_ok = 32'(in_row) < TILES_Y;
    in_row_a  = ROW_W'(in_row);
    in_tx     = TX_W'(in_x >> TILE_W_LOG2);
    in_ty     = ROW_W'(in_y >> TILE_H_LOG2);
    // A cell on a tile edge also dirties the tile across that edge.
    edge_l    = (in_x[TILE_W_LOG2-1:0] == '0) && (in_tx != '0);
    edge_r    = (in_x[TILE_W_LOG2-1:0] == '1) && (in_tx != TX_W'(TILES_X - 1));
    edge_d    = (in_y[TILE_H_LOG2-1:0] == '0) && (in_ty != '0);
    edge_u    = (in_y[TILE_H_LOG2-1:0] == '1) && (in_ty != ROW_W'(TILES_Y - 1));
    in_bit    = TILES_X'(1) << in_tx;
    in_mask   = in_bit;
    if (edge_l) begin
      in_mask = in_mask | (in_bit >> 1);
    end
    if (edge_r) begin
      in_mask = in_mask | (in_bit << 1);
    end
  end

  // Latched request.
  logic [ROW_W-1:0]   mk_row, nb_row, sc_row;
  logic [TILES_X-1:0] mk_mask, mk_bit;
  logic               nb_en;

  // Flag memories; a row whose valid bit is clear reads as all clean.
  logic [TILES_Y-1:0] pend_vld, cur_vld;
  logic               pend_we, cur_we;
  logic [ROW_W-1:0]   pend_raddr, pend_waddr, rd_row;
  logic [TILES_X-1:0] pend_wdata, pend_rdata, cur_rdata;
  logic [TILES_X-1:0] pend_word, cur_word;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    if (state == ST_IDLE) begin
      pend_raddr = (in_func == FUNC_MARK) ? in_ty : in_row_a;
    end else begin
      pend_raddr = nb_row;
    end
    case (state)
      ST_MK_NB: rd_row = nb_row;
      ST_SC_LD: rd_row = sc_row;
      default:  rd_row = mk_row;
    endcase
    pend_word  = pend_vld[rd_row] ? pend_rdata : '0;
    cur_word   = cur_vld[sc_row] ? cur_rdata : '0;
    pend_we    = (state == ST_MK_WR) || (state == ST_MK_NB);
    pend_waddr = (state == ST_MK_NB) ? nb_row : mk_row;
    pend_wdata = pend_word | ((state == ST_MK_NB) ? mk_bit : mk_mask);
    cur_we     = (state == ST_SC_LD);
  end

  dtt_ram #(
    .WIDTH (TILES_X),
    .DEPTH (TILES_Y)
  ) u_pending (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  // The current bitmap takes the pending row at scan load; pending is cleared
  // by dropping its valid bit.
  dtt_ram #(
    .WIDTH (TILES_X),
    .DEPTH (TILES_Y)
  ) u_current (
    .clk   (clk),
    .we    (cur_we),
    .waddr (sc_row),
    .wdata (pend_word),
    .raddr (in_row_a),
    .rdata (cur_rdata)
  );

  // Row walker.
  logic [TILES_X-1:0]        dirty_word;
  logic [TX_W-1:0]           tx;
  logic                      y_hit;
  logic [9:0]                box_y0, box_y1;
  logic                      run_open;
  logic [9:0]                run_min_x, run_max_x;
  logic signed [COORD_W-1:0] x0c, x1c, y0c, y1c;
  logic                      in_win, have_res, stall;
  res_t                      walk_res;

  // Staging slot: a result waits here until it is known whether it is the last.
  res_t stg_res;
  logic stg_valid;

  logic out_free, out_load, out_last;
  res_t out_data, result;

  always_comb begin
    x0c    = signed'(COORD_W'({tx, {TILE_W_LOG2{1'b0}}}));
    x1c    = x0c + COORD_W'(TILE_W);
    y0c    = signed'(COORD_W'({sc_row, {TILE_H_LOG2{1'b0}}}));
    y1c    = y0c + COORD_W'(TILE_H);
    in_win = y_hit && (x0c < win.x_hi) && (x1c > win.x_lo);

    // A clean tile closes an open run; a dirty tile inside the window is redrawn.
    if ((state == ST_SC_WALK) && dirty_word[0]) begin
      have_res       = in_win;
      walk_res.kind  = KIND_REDRAW;
      walk_res.min_x = 10'(x0c);
      walk_res.max_x = 10'(x1c);
    end else begin
      have_res       = run_open && ((state == ST_SC_WALK) || (state == ST_SC_END));
      walk_res.kind  = KIND_REGION;
      walk_res.min_x = run_min_x;
      walk_res.max_x = run_max_x;
    end
    walk_res.min_y = box_y0;
    walk_res.max_y = box_y1;

    out_free = !m_tvalid || m_tready;
    stall    = have_res && stg_valid && !out_free;

    out_data = stg_res;
    out_last = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_MK_ERR: begin
        out_load = out_free;
        out_data = '{kind: KIND_RANGE, default: '0};
        out_last = 1'b1;
      end
      ST_SC_WALK, ST_SC_END: begin
        out_load = have_res && stg_valid && out_free;
      end
      ST_SC_FIN: begin
        out_load = stg_valid && out_free;
        out_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend_vld  <= '0;
      cur_vld   <= '0;
      run_open  <= 1'b0;
      stg_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        result   <= out_data;
        m_tlast  <= out_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mk_row  <= in_ty;
            mk_mask <= in_mask;
            mk_bit  <= in_bit;
            nb_en   <= edge_d || edge_u;
            nb_row  <= edge_u ? (in_ty + ROW_W'(1)) : (in_ty - ROW_W'(1));
            sc_row  <= in_row_a;
            if (in_func == FUNC_MARK) begin
              state <= in_oor ? ST_MK_ERR : ST_MK_WR;
            end else if (in_row_ok) begin
              state <= ST_SC_LD;
            end
          end
        end
        ST_MK_WR: begin
          pend_vld[mk_row] <= 1'b1;
          state <= nb_en ? ST_MK_NB : ST_IDLE;
        end
        ST_MK_NB: begin
          pend_vld[nb_row] <= 1'b1;
          state <= ST_IDLE;
        end
        ST_MK_ERR: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_SC_LD: begin
          pend_vld[sc_row] <= 1'b0;
          cur_vld[sc_row]  <= 1'b1;
          dirty_word       <= cur_word;
          tx               <= '0;
          run_open         <= 1'b0;
          y_hit            <= (y0c < win.y_hi) && (y1c > win.y_lo);
          box_y0           <= 10'(y0c);
          box_y1           <= 10'(y1c);
          state            <= ST_SC_WALK;
        end
        ST_SC_WALK: begin
          if (!stall) begin
            if (have_res) begin
              stg_res   <= walk_res;
              stg_valid <= 1'b1;
            end
            if (!dirty_word[0]) begin
              run_open <= 1'b0;
            end else if (in_win) begin
              if (!run_open) begin
                run_min_x <= 10'(x0c);
                run_open  <= 1'b1;
              end
              run_max_x <= 10'(x1c);
            end
            dirty_word <= dirty_word >> 1;
            tx         <= tx + TX_W'(1);
            if (tx == TX_W'(TILES_X - 1)) begin
              state <= ST_SC_END;
            end
          end
        end
        ST_SC_END: begin
          if (!stall) begin
            if (have_res) begin
              stg_res   <= walk_res;
              stg_valid <= 1'b1;
            end
            run_open <= 1'b0;
            state    <= ST_SC_FIN;
          end
        end
        ST_SC_FIN: begin
          if (!stg_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            stg_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {result.max_y, result.max_x, result.min_y, result.min_x};
  assign m_tuser = result.kind;

endmodule

`default_nettype wire
